FILE: hdl/adsi_pkg.sv
// Shared types and constants for the ASCII decimal parser.
// Character codes, parse phases and parameter defaults; no dependencies.
package adsi_pkg;

  // Parameter defaults
  localparam int MANTISSA_BITS_DEF       = 48;
  localparam int MAX_FRACTION_DIGITS_DEF = 31;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // Parse phases
  typedef enum logic [2:0] {
    PH_BLANKS,
    PH_SIGNED,
    PH_DIGITS,
    PH_POINT,
    PH_DONE
  } phase_t;

endpackage

FILE: hdl/ascii_decimal_to_scaled_int.sv
// Stream parser from ASCII decimal text to a signed mantissa and a fraction digit count.
// One character enters per cycle and passes through an input register, one stage of
// parse logic and a result register. The block takes a character in every cycle; the
// only stall is a final character that meets a result still waiting in the output
// register, and it lasts until that result is taken. value = mantissa / 10^frac_digits;
// overflow marks saturation of the mantissa magnitude or of the digit count.
// Depends on adsi_pkg.
module ascii_decimal_to_scaled_int #(
  parameter int MANTISSA_BITS       = adsi_pkg::MANTISSA_BITS_DEF,
  parameter int MAX_FRACTION_DIGITS = adsi_pkg::MAX_FRACTION_DIGITS_DEF,
  localparam int FB    = $clog2(MAX_FRACTION_DIGITS + 1),
  localparam int OUT_W = ((MANTISSA_BITS + FB + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] char_code
  input  logic             s_tlast,   // is_last
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // mantissa, then frac_digits, zero fill
  output logic             m_tuser    // overflow
);

  localparam int AW = MANTISSA_BITS - 1;
  localparam int PW = MANTISSA_BITS + 3;
  localparam logic [PW-1:0] MAG_MAX = PW'({AW{1'b1}});
  localparam logic [FB-1:0] FRAC_MAX = FB'(MAX_FRACTION_DIGITS);

  // Input register
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_last;
  logic       advance;

  // Parse state
  adsi_pkg::phase_t phase, phase_next;
  logic          negative, negative_next;
  logic [AW-1:0] accumulator, accumulator_next;
  logic [FB-1:0] fraction_count, fraction_count_next;
  logic          point_seen, point_seen_next;
  logic          saturated, saturated_next;

  // Result register
  logic                     out_valid;
  logic [MANTISSA_BITS-1:0] out_mant;
  logic [FB-1:0]            out_frac;
  logic                     out_ovf;

  // Digit arithmetic
  logic          is_digit, is_blank;
  logic [3:0]    digit;
  logic [PW-1:0] acc_ext, product;
  logic          mag_over;
  logic [MANTISSA_BITS-1:0] mant_pos;

  // Hold a final character while the result register is still full
  assign advance  = in_valid && !(in_last && out_valid && !m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Classify the character and form accumulator*10 + digit
  assign is_digit = (in_char >= adsi_pkg::CH_ZERO) && (in_char <= adsi_pkg::CH_NINE);
  assign is_blank = in_char inside {adsi_pkg::CH_SPACE, [adsi_pkg::CH_TAB:adsi_pkg::CH_CR]};
  assign digit    = 4'(in_char - adsi_pkg::CH_ZERO);
  assign acc_ext  = PW'(accumulator);
  assign product  = (acc_ext << 3) + (acc_ext << 1) + PW'(digit);
  assign mag_over = product > MAG_MAX;

  // Next parse state for the character in the input register
  always_comb begin
    phase_next          = phase;
    negative_next       = negative;
    accumulator_next    = accumulator;
    fraction_count_next = fraction_count;
    point_seen_next     = point_seen;
    saturated_next      = saturated;
    case (phase)
      adsi_pkg::PH_BLANKS, adsi_pkg::PH_SIGNED, adsi_pkg::PH_DIGITS,
      adsi_pkg::PH_POINT: begin
        if (is_digit) begin
          if (mag_over) begin
            accumulator_next = {AW{1'b1}};
            saturated_next   = 1'b1;
          end else begin
            accumulator_next = product[AW-1:0];
          end
          if (point_seen) begin
            if (fraction_count >= FRAC_MAX) begin
              saturated_next = 1'b1;
            end else begin
              fraction_count_next = fraction_count + 1'b1;
            end
          end
          phase_next = adsi_pkg::PH_DIGITS;
        end else if (phase == adsi_pkg::PH_BLANKS && is_blank) begin
          phase_next = adsi_pkg::PH_BLANKS;
        end else if (phase == adsi_pkg::PH_BLANKS && in_char == adsi_pkg::CH_MINUS) begin
          negative_next = 1'b1;
          phase_next    = adsi_pkg::PH_SIGNED;
        end else if (phase == adsi_pkg::PH_BLANKS && in_char == adsi_pkg::CH_PLUS) begin
          phase_next = adsi_pkg::PH_SIGNED;
        end else if (phase == adsi_pkg::PH_DIGITS && in_char == adsi_pkg::CH_POINT) begin
          point_seen_next     = 1'b1;
          fraction_count_next = '0;
          phase_next          = adsi_pkg::PH_POINT;
        end else begin
          phase_next = adsi_pkg::PH_DONE;
        end
      end
      default: begin
        phase_next = adsi_pkg::PH_DONE;
      end
    endcase
  end

  // Advance the state; return to the start after the final character
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= adsi_pkg::PH_BLANKS;
      negative       <= 1'b0;
      accumulator    <= '0;
      fraction_count <= '0;
      point_seen     <= 1'b0;
      saturated      <= 1'b0;
    end else if (advance) begin
      if (in_last) begin
        phase          <= adsi_pkg::PH_BLANKS;
        negative       <= 1'b0;
        accumulator    <= '0;
        fraction_count <= '0;
        point_seen     <= 1'b0;
        saturated      <= 1'b0;
      end else begin
        phase          <= phase_next;
        negative       <= negative_next;
        accumulator    <= accumulator_next;
        fraction_count <= fraction_count_next;
        point_seen     <= point_seen_next;
        saturated      <= saturated_next;
      end
    end
  end

  // Apply the sign; a zero magnitude stays zero under negation
  assign mant_pos = {1'b0, accumulator_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance && in_last) begin
      out_mant <= negative_next ? -mant_pos : mant_pos;
      out_frac <= fraction_count_next;
      out_ovf  <= saturated_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'({out_frac, out_mant});
  assign m_tuser  = out_ovf;

`ifndef ASSERT_OFF
  // The most negative code never appears: magnitude saturates one below it
  a_no_min_mant: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_mant != {1'b1, {AW{1'b0}}})
    else $error("mantissa holds the most negative code");

  // The state is back at its start after a final character
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (phase == adsi_pkg::PH_BLANKS && accumulator == '0
                              && fraction_count == '0 && !saturated))
    else $error("parse state not cleared after final character");

  // No fraction digits are counted before a point
  a_frac_needs_point: assert property (@(posedge clk) disable iff (rst)
    !point_seen |-> fraction_count == '0)
    else $error("fraction digits counted without a point");

  // While skipping blanks nothing has been collected yet
  a_blanks_clean: assert property (@(posedge clk) disable iff (rst)
    phase == adsi_pkg::PH_BLANKS |-> (accumulator == '0 && !negative && !point_seen))
    else $error("state collected during blank skipping");

  // Input stalls only for a final character facing a full, blocked result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && in_last && out_valid && !m_tready))
    else $error("input stalled without cause");
`endif

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for ascii_decimal_to_scaled_int: character requests go in, parsed numbers come out.
// A scoreboard class predicts each number from the characters taken and checks the results.
// Depends on adsi_pkg and the parser RTL.
module tb_top;

  localparam int MB    = adsi_pkg::MANTISSA_BITS_DEF;
  localparam int MAXF  = adsi_pkg::MAX_FRACTION_DIGITS_DEF;
  localparam int FB    = $clog2(MAXF + 1);
  localparam int OUT_W = ((MB + FB + 7) / 8) * 8;

  localparam longint unsigned MAG_MAX = (64'd1 << (MB - 1)) - 1;

  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_VT  = 8'd11;
  localparam logic [7:0] CH_FF  = 8'd12;

  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 3000;
  localparam int RANDOM_CHARS = 500;

  typedef enum {RX_ALWAYS, RX_MOSTLY, RX_EVERY_FOURTH, RX_SPARSE} rx_mode_t;

  typedef struct {
    logic signed [MB-1:0] mantissa;
    logic [FB-1:0]        frac_digits;
    logic                 overflow;
  } number_t;

  // Parse state mirror plus the queue of numbers still owed by the block
  class decimal_scoreboard;
    adsi_pkg::phase_t phase = adsi_pkg::PH_BLANKS;
    logic           negative = 1'b0;
    logic [MB-2:0]  magnitude = '0;
    logic [FB-1:0]  frac_count = '0;
    logic           point_seen = 1'b0;
    logic           saturated = 1'b0;
    number_t        expected_numbers[$];
    int             errors = 0;

    // Fold one digit into the magnitude, saturating at the largest value
    function void add_digit(logic [7:0] c);
      longint unsigned d;
      longint unsigned bound;
      d = 64'(c - adsi_pkg::CH_ZERO);
      bound = (MAG_MAX - d) / 10;
      if (magnitude > bound) begin
        magnitude = (MB-1)'(MAG_MAX);
        saturated = 1'b1;
      end else begin
        magnitude = (MB-1)'(magnitude * 10 + d);
      end
      if (point_seen) begin
        if (frac_count >= MAXF) saturated = 1'b1;
        else frac_count++;
      end
      phase = adsi_pkg::PH_DIGITS;
    endfunction

    // Advance the parse by one accepted character; owe a number on the last one
    function void take_char(logic [7:0] c, logic last);
      number_t num;
      logic [MB-1:0] mag;
      logic is_digit;
      is_digit = (c >= adsi_pkg::CH_ZERO) && (c <= adsi_pkg::CH_NINE);
      case (phase)
        adsi_pkg::PH_BLANKS: begin
          if (c == adsi_pkg::CH_SPACE || (c >= adsi_pkg::CH_TAB && c <= adsi_pkg::CH_CR)) begin
            phase = adsi_pkg::PH_BLANKS;
          end else if (c == adsi_pkg::CH_MINUS) begin
            negative = 1'b1;
            phase = adsi_pkg::PH_SIGNED;
          end else if (c == adsi_pkg::CH_PLUS) begin
            phase = adsi_pkg::PH_SIGNED;
          end else if (is_digit) begin
            add_digit(c);
          end else begin
            phase = adsi_pkg::PH_DONE;
          end
        end
        adsi_pkg::PH_SIGNED, adsi_pkg::PH_POINT: begin
          if (is_digit) add_digit(c);
          else phase = adsi_pkg::PH_DONE;
        end
        adsi_pkg::PH_DIGITS: begin
          if (is_digit) begin
            add_digit(c);
          end else if (c == adsi_pkg::CH_POINT) begin
            point_seen = 1'b1;
            frac_count = '0;
            phase = adsi_pkg::PH_POINT;
          end else begin
            phase = adsi_pkg::PH_DONE;
          end
        end
        default: phase = adsi_pkg::PH_DONE;
      endcase
      if (!last) return;
      mag = {1'b0, magnitude};
      num.mantissa = (negative && mag != 0) ? -mag : mag;
      num.frac_digits = frac_count;
      num.overflow = saturated;
      expected_numbers.push_back(num);
      // start over for the next string
      phase = adsi_pkg::PH_BLANKS;
      negative = 1'b0;
      magnitude = '0;
      frac_count = '0;
      point_seen = 1'b0;
      saturated = 1'b0;
    endfunction

    // Compare one result against the oldest owed number
    function void check_number(logic [OUT_W-1:0] tdata, logic tuser);
      number_t want;
      if (expected_numbers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, mantissa %0d frac_digits %0d overflow %0b",
                 $time, $signed(tdata[MB-1:0]), tdata[MB+FB-1:MB], tuser);
        return;
      end
      want = expected_numbers.pop_front();
      if (tdata[MB-1:0] !== want.mantissa) begin
        errors++;
        $display("%0t: mantissa expected %0d, actual %0d",
                 $time, want.mantissa, $signed(tdata[MB-1:0]));
      end
      if (tdata[MB+FB-1:MB] !== want.frac_digits) begin
        errors++;
        $display("%0t: frac_digits expected %0d, actual %0d",
                 $time, want.frac_digits, tdata[MB+FB-1:MB]);
      end
      if (tuser !== want.overflow) begin
        errors++;
        $display("%0t: overflow expected %0b, actual %0b", $time, want.overflow, tuser);
      end
      if (tdata[OUT_W-1:MB+FB] !== '0) begin
        errors++;
        $display("%0t: fill bits expected 0, actual %0h", $time, tdata[OUT_W-1:MB+FB]);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;   // [7:0] char_code
  logic             s_tlast;   // is_last
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;   // mantissa, then frac_digits, zero fill
  logic             m_tuser;   // overflow

  decimal_scoreboard sb = new();
  bit          hold_off_req = 1'b0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  ascii_decimal_to_scaled_int i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watch both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_number(m_tdata, m_tuser);
    if (!rst && s_tvalid && s_tready) sb.take_char(s_tdata, s_tlast);
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result receiver: stall patterns that change now and then, plus one long hold-off
  initial begin : receiver
    rx_mode_t    mode;
    int unsigned left;
    int unsigned tick;
    m_tready = 1'b0;
    mode = RX_ALWAYS;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // hold long enough for the parser to back up into its input
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(16, 80);
        end
        left--;
        tick++;
        case (mode)
          RX_ALWAYS:       m_tready <= 1'b1;
          RX_MOSTLY:       m_tready <= ($urandom_range(0, 9) < 7);
          RX_EVERY_FOURTH: m_tready <= (tick % 4 == 0);
          default:         m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one character request and wait until it is taken; bursts with random gaps
  task automatic send_char(logic [7:0] c, logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_text(logic [7:0] text[$]);
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
  endtask

  function automatic logic [7:0] rand_digit();
    return adsi_pkg::CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Build one random string: mostly well-formed numbers, some noise and broken ones
  function automatic void build_number(output logic [7:0] text[$]);
    int unsigned pick;
    int unsigned ndig;
    int unsigned nfrac;
    int unsigned pos;
    string near_max;
    near_max = "14073748835532";
    text = {};
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 2))
      text.push_back(($urandom_range(0, 5) == 5) ? adsi_pkg::CH_SPACE
                                                 : 8'($urandom_range(9, 13)));
    case ($urandom_range(0, 2))
      0: text.push_back(adsi_pkg::CH_MINUS);
      1: text.push_back(adsi_pkg::CH_PLUS);
      default: ;
    endcase
    if (pick < 14) begin
      // land right at the edge of the mantissa range
      foreach (near_max[i]) text.push_back(near_max[i]);
      text.push_back(rand_digit());
    end else begin
      ndig = (pick < 22) ? $urandom_range(16, 20) : (pick < 27) ? 0 : $urandom_range(1, 8);
      repeat (ndig) text.push_back(rand_digit());
    end
    if ($urandom_range(0, 1)) begin
      nfrac = (pick >= 27 && pick < 33) ? $urandom_range(28, 40) : $urandom_range(0, 5);
      text.push_back(adsi_pkg::CH_POINT);
      repeat (nfrac) text.push_back(rand_digit());
      // a further point restarts the fraction count
      if ($urandom_range(0, 9) == 0) begin
        text.push_back(adsi_pkg::CH_POINT);
        repeat ($urandom_range(0, 3)) text.push_back(rand_digit());
      end
    end
    if (pick >= 85) begin
      pos = $urandom_range(0, text.size());
      text.insert(pos, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
    end
    if (text.size() == 0) text.push_back(rand_digit());
  endfunction

  // Main sequence: reset, directed strings, random strings, drain
  initial begin : stimulus
    logic [7:0] text[$];
    logic [7:0] blank_run[7];
    int unsigned sent;
    bit hold_done;
    blank_run = '{adsi_pkg::CH_TAB, CH_LF, CH_VT, CH_FF, adsi_pkg::CH_CR,
                  adsi_pkg::CH_SPACE, adsi_pkg::CH_NINE};
    sent = 0;
    hold_done = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corner strings
    send_str("-0");
    send_str("- 1");
    send_str("+7.2");
    send_str("1.2.9");
    send_str("9..1");
    send_str("12.");
    send_str(".5");
    foreach (blank_run[i]) send_char(blank_run[i], i == 6);
    send_char(CH_NUL, 1'b1);
    send_char(adsi_pkg::CH_NINE, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(adsi_pkg::CH_ZERO, 1'b1);

    // random strings; hold off the receiver once partway through
    while (sent < RANDOM_CHARS) begin
      build_number(text);
      send_text(text);
      sent += text.size();
      if (!hold_done && sent > RANDOM_CHARS / 3) begin
        hold_off_req = 1'b1;
        hold_done = 1'b1;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    // drain the owed numbers, then let the pipeline settle
    while (sb.expected_numbers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/adsi_pkg.sv
hdl/ascii_decimal_to_scaled_int.sv
tb/sv/tb_top.sv
